FILE: rtl/core/bpm_pkg.sv
// Shared types and codes for the buffer pool mailbox.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package bpm_pkg;

   localparam int HANDLE_W = 4;
   localparam int DEFAULT_NUM_BUFFERS = 16;

   typedef logic [1:0] op_type;
   typedef logic [1:0] status_type;
   typedef logic [HANDLE_W-1:0] handle_type;

   localparam op_type OP_ALLOC   = 2'd0;
   localparam op_type OP_SEND    = 2'd1;
   localparam op_type OP_RECEIVE = 2'd2;
   localparam op_type OP_DISPOSE = 2'd3;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/core/buffer_pool_mailbox.sv
// Buffer pool with mailbox: a free ring and a message ring of handles.
// Depends on bpm_pkg; both rings are synchronous memories inside this module.
//
//   channel   ports                               handshake
//   request   req_op, req_handle_in               start && !busy
//   response  rsp_handle_out, rsp_status          rsp_valid, one cycle
//
// One transaction is accepted per cycle while busy is low; its response appears on the
// cycle after acceptance, set by the registered reads of the ring memories.
// Pointers and counts update at acceptance, so back-to-back transactions
// always see the state left by the one before.
// After reset, busy stays high while the free ring is
// loaded with handles in order, one entry per cycle.
// The receiver cannot stall; a response is shown for exactly one cycle.
`default_nettype none

module buffer_pool_mailbox
   import bpm_pkg::*;
#(
   parameter int NUM_BUFFERS = DEFAULT_NUM_BUFFERS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire op_type     req_op,
   input  wire handle_type req_handle_in,
   output logic            rsp_valid,
   output handle_type      rsp_handle_out,
   output status_type      rsp_status
);

   localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam int CNT_W = $clog2(NUM_BUFFERS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUFFERS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_BUFFERS);

   handle_type free_mem [NUM_BUFFERS];
   handle_type msg_mem  [NUM_BUFFERS];

   logic [IDX_W-1:0] free_head_ff, free_head_in, free_tail_ff, free_tail_in;
   logic [IDX_W-1:0] msg_head_ff, msg_head_in, msg_tail_ff, msg_tail_in;
   logic [CNT_W-1:0] free_count_ff, free_count_in, msg_count_ff, msg_count_in;
   logic [IDX_W-1:0] init_idx_ff, init_idx_in;
   logic             init_active_ff, init_active_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_pop_ff, rsp_pop_in;
   logic       rsp_from_msg_ff, rsp_from_msg_in;
   status_type rsp_status_ff, rsp_status_in;
   handle_type free_rd_ff, msg_rd_ff;

   logic accept;
   logic free_pop, free_push, msg_pop, msg_push;
   logic free_we;
   logic [IDX_W-1:0] free_waddr;
   handle_type free_wdata;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   assign busy   = init_active_ff;
   assign accept = start && !init_active_ff;

   always_comb begin
      free_pop  = accept && (req_op == OP_ALLOC)   && (free_count_ff != '0);
      msg_push  = accept && (req_op == OP_SEND)    && (msg_count_ff != FULL_CNT);
      msg_pop   = accept && (req_op == OP_RECEIVE) && (msg_count_ff != '0);
      free_push = accept && (req_op == OP_DISPOSE) && (free_count_ff != FULL_CNT);

      unique case (req_op)
         OP_ALLOC:   rsp_status_in = free_pop  ? ST_OK : ST_EMPTY;
         OP_SEND:    rsp_status_in = msg_push  ? ST_OK : ST_FULL;
         OP_RECEIVE: rsp_status_in = msg_pop   ? ST_OK : ST_EMPTY;
         OP_DISPOSE: rsp_status_in = free_push ? ST_OK : ST_FULL;
         default:    rsp_status_in = ST_OK;
      endcase

      rsp_valid_in    = accept;
      rsp_pop_in      = free_pop || msg_pop;
      rsp_from_msg_in = (req_op == OP_RECEIVE);

      free_head_in  = free_pop  ? next_idx(free_head_ff) : free_head_ff;
      free_tail_in  = free_push ? next_idx(free_tail_ff) : free_tail_ff;
      msg_head_in   = msg_pop   ? next_idx(msg_head_ff)  : msg_head_ff;
      msg_tail_in   = msg_push  ? next_idx(msg_tail_ff)  : msg_tail_ff;
      free_count_in = free_count_ff + CNT_W'(free_push) - CNT_W'(free_pop);
      msg_count_in  = msg_count_ff + CNT_W'(msg_push) - CNT_W'(msg_pop);

      init_idx_in    = init_active_ff ? next_idx(init_idx_ff) : init_idx_ff;
      init_active_in = init_active_ff && (init_idx_ff != LAST_IDX);

      // The loading sweep owns the free ring write port until it finishes.
      free_we    = init_active_ff || free_push;
      free_waddr = init_active_ff ? init_idx_ff : free_tail_ff;
      free_wdata = init_active_ff ? HANDLE_W'(init_idx_ff) : req_handle_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff   <= '0;
         free_tail_ff   <= '0;
         msg_head_ff    <= '0;
         msg_tail_ff    <= '0;
         free_count_ff  <= FULL_CNT;
         msg_count_ff   <= '0;
         init_idx_ff    <= '0;
         init_active_ff <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         free_head_ff   <= free_head_in;
         free_tail_ff   <= free_tail_in;
         msg_head_ff    <= msg_head_in;
         msg_tail_ff    <= msg_tail_in;
         free_count_ff  <= free_count_in;
         msg_count_ff   <= msg_count_in;
         init_idx_ff    <= init_idx_in;
         init_active_ff <= init_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pop_ff      <= rsp_pop_in;
      rsp_from_msg_ff <= rsp_from_msg_in;
      rsp_status_ff   <= rsp_status_in;
   end

   // A pop reads at the head while any push writes at the tail; a pop on the
   // next cycle reads the entry only after the write edge, so no bypass is needed.
   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_waddr] <= free_wdata;
      end
      free_rd_ff <= free_mem[free_head_ff];
   end

   always_ff @(posedge clock) begin
      if (msg_push) begin
         msg_mem[msg_tail_ff] <= req_handle_in;
      end
      msg_rd_ff <= msg_mem[msg_head_ff];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_handle_out = !rsp_pop_ff     ? '0 :
                           rsp_from_msg_ff ? msg_rd_ff : free_rd_ff;

endmodule

`default_nettype wire

FILE: rtl/core/bpm_checker.sv
// Port-level checks for the buffer pool mailbox, bound to the top level.
// Depends on bpm_pkg and buffer_pool_mailbox.
`default_nettype none

module bpm_checker
   import bpm_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire op_type     req_op,
   input wire logic       rsp_valid,
   input wire handle_type rsp_handle_out,
   input wire status_type rsp_status
);

   // Every accepted transaction gets its response on the next cycle.
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid)
      else $error("accepted transaction produced no response");

   // No response appears without a transaction accepted the cycle before.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !reset))
      else $error("response without an accepted transaction");

   // Failed operations carry a zero handle.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_handle_out == '0)
      else $error("nonzero handle on a failed operation");

   // Pushes return a zero handle and never report an empty ring.
   a_push_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ($past(req_op) == OP_SEND || $past(req_op) == OP_DISPOSE)
      |-> rsp_handle_out == '0 && rsp_status != ST_EMPTY)
      else $error("bad push response");

   // The free ring loads after every reset, so the block starts busy.
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("not busy after reset");

endmodule

bind buffer_pool_mailbox bpm_checker u_bpm_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_op         (req_op),
   .rsp_valid      (rsp_valid),
   .rsp_handle_out (rsp_handle_out),
   .rsp_status     (rsp_status)
);

`default_nettype wire
